// ----- rtl/bufuart_pkg.sv -----
// Shared operation codes, status codes and result record for the UART ring bridge.
package bufuart_pkg;

  typedef enum logic [2:0] {
    OP_OPEN    = 3'd0,
    OP_CLOSE   = 3'd1,
    OP_WRITE   = 3'd2,
    OP_READ    = 3'd3,
    OP_SERVICE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_WAIT = 2'd1,
    ST_BUSY = 2'd2
  } status_e;

  typedef struct packed {
    status_e status;
    logic    rd_sel;
    logic    thr_write;
    logic    rx_irq_en;
    logic    tx_irq_en;
    logic    tx_room;
    logic    rx_data;
  } res_t;

endpackage

// ----- rtl/buffered_uart_ring_fifo_bridge_core.sv -----
// Receive and transmit rings in front of a UART, one operation per item.
// The result is registered and becomes valid in the cycle after the input is accepted.
// Throughput: one item per cycle while the result is taken; each ring memory has one write port and one read port.
// The next item is accepted while the current result is being taken.
// Reset clears pointers, interrupt enables and the port-open flag; ring memories are not cleared.
module buffered_uart_ring_fifo_bridge_core #(
  parameter int RING_DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [7:0] data_byte_i,
  input  logic       data_ready_i,
  input  logic       thr_empty_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] status_o,
  output logic [7:0] read_byte_o,
  output logic       thr_write_o,
  output logic [7:0] thr_byte_o,
  output logic       rx_irq_enable_o,
  output logic       tx_irq_enable_o,
  output logic       tx_has_room_o,
  output logic       rx_has_data_o
);
  import bufuart_pkg::*;

  localparam int PtrMod = 2 * RING_DEPTH;
  localparam int PtrW   = $clog2(PtrMod);
  localparam int SlotW  = $clog2(RING_DEPTH);
  localparam int ExtW   = PtrW + 1;

  localparam logic [PtrW-1:0] PtrLast = PtrW'(PtrMod - 1);
  localparam logic [PtrW-1:0] PtrDep  = PtrW'(RING_DEPTH);
  localparam logic [ExtW-1:0] ExtDep  = ExtW'(RING_DEPTH);
  localparam logic [ExtW-1:0] ExtMod  = ExtW'(PtrMod);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrLast) ? '0 : p + PtrW'(1);
  endfunction

  function automatic logic [SlotW-1:0] ptr_slot(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] s;
    s = (p >= PtrDep) ? p - PtrDep : p;
    return s[SlotW-1:0];
  endfunction

  function automatic logic [ExtW-1:0] ring_fill(input logic [PtrW-1:0] head,
                                                input logic [PtrW-1:0] tail);
    logic [ExtW-1:0] h;
    logic [ExtW-1:0] t;
    h = {1'b0, head};
    t = {1'b0, tail};
    return (t >= h) ? t - h : t + ExtMod - h;
  endfunction

  function automatic logic ring_full(input logic [PtrW-1:0] head,
                                     input logic [PtrW-1:0] tail);
    return ring_fill(head, tail) == ExtDep;
  endfunction

  logic [PtrW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [PtrW-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic            rx_en_q, rx_en_d, tx_en_q, tx_en_d, open_q, open_d;
  logic            out_valid_q;
  res_t            res_q, res_d;
  logic            rx_wr, tx_wr;
  logic            accept;

  logic [7:0]      rx_mem [RING_DEPTH];
  logic [7:0]      tx_mem [RING_DEPTH];
  logic [7:0]      rx_rdata_q, tx_rdata_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    rx_head_d = rx_head_q;
    rx_tail_d = rx_tail_q;
    tx_head_d = tx_head_q;
    tx_tail_d = tx_tail_q;
    rx_en_d   = rx_en_q;
    tx_en_d   = tx_en_q;
    open_d    = open_q;
    rx_wr     = 1'b0;
    tx_wr     = 1'b0;
    res_d     = '0;
    res_d.status = ST_DONE;
    unique case (op_e'(op_i))
      OP_OPEN: begin
        if (open_q) begin
          res_d.status = ST_BUSY;
        end else begin
          rx_head_d = '0;
          rx_tail_d = '0;
          tx_head_d = '0;
          tx_tail_d = '0;
          rx_en_d   = 1'b1;
          open_d    = 1'b1;
        end
      end
      OP_CLOSE: begin
        rx_en_d = 1'b0;
        tx_en_d = 1'b0;
        open_d  = 1'b0;
      end
      OP_WRITE: begin
        if (ring_full(tx_head_q, tx_tail_q)) begin
          res_d.status = ST_WAIT;
        end else begin
          tx_wr     = 1'b1;
          tx_tail_d = ptr_next(tx_tail_q);
          tx_en_d   = 1'b1;
        end
      end
      OP_READ: begin
        if (rx_head_q == rx_tail_q) begin
          res_d.status = ST_WAIT;
        end else begin
          res_d.rd_sel = 1'b1;
          rx_head_d    = ptr_next(rx_head_q);
          rx_en_d      = 1'b1;
        end
      end
      OP_SERVICE: begin
        if (data_ready_i && !ring_full(rx_head_q, rx_tail_q)) begin
          rx_wr     = 1'b1;
          rx_tail_d = ptr_next(rx_tail_q);
        end
        if (thr_empty_i && (tx_head_q != tx_tail_q)) begin
          res_d.thr_write = 1'b1;
          tx_head_d       = ptr_next(tx_head_q);
        end
        if (tx_head_d == tx_tail_d) begin
          tx_en_d = 1'b0;
        end
        if (ring_full(rx_head_d, rx_tail_d)) begin
          rx_en_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
    res_d.rx_irq_en = rx_en_d;
    res_d.tx_irq_en = tx_en_d;
    res_d.tx_room   = !ring_full(tx_head_d, tx_tail_d);
    res_d.rx_data   = rx_head_d != rx_tail_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      rx_en_q     <= 1'b0;
      tx_en_q     <= 1'b0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rx_head_q <= rx_head_d;
        rx_tail_q <= rx_tail_d;
        tx_head_q <= tx_head_d;
        tx_tail_q <= tx_tail_d;
        rx_en_q   <= rx_en_d;
        tx_en_q   <= tx_en_d;
        open_q    <= open_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && rx_wr) begin
      rx_mem[ptr_slot(rx_tail_q)] <= rx_byte_i;
    end
    if (accept) begin
      rx_rdata_q <= rx_mem[ptr_slot(rx_head_q)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && tx_wr) begin
      tx_mem[ptr_slot(tx_tail_q)] <= data_byte_i;
    end
    if (accept) begin
      tx_rdata_q <= tx_mem[ptr_slot(tx_head_q)];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = res_q.status;
  assign read_byte_o     = res_q.rd_sel ? rx_rdata_q : 8'd0;
  assign thr_write_o     = res_q.thr_write;
  assign thr_byte_o      = res_q.thr_write ? tx_rdata_q : 8'd0;
  assign rx_irq_enable_o = res_q.rx_irq_en;
  assign tx_irq_enable_o = res_q.tx_irq_en;
  assign tx_has_room_o   = res_q.tx_room;
  assign rx_has_data_o   = res_q.rx_data;

  a_rx_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_fill(rx_head_q, rx_tail_q) <= ExtDep)
    else $error("receive ring holds more than its depth");

  a_tx_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_fill(tx_head_q, tx_tail_q) <= ExtDep)
    else $error("transmit ring holds more than its depth");

  a_send_leaves_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && thr_write_o |-> tx_has_room_o)
    else $error("byte sent but transmit ring still reported full");

  a_wait_no_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_WAIT) |-> (read_byte_o == 8'd0) && !thr_write_o)
    else $error("wait status with a byte transferred");

  a_close_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(open_q) |-> $past(accept && (op_i == OP_CLOSE)))
    else $error("port closed without a close item");

endmodule
